/* src/jsdp_pkg.sv */
package jsdp_pkg;

    localparam int BYTE_W   = 8;
    localparam int DIM_W    = 16;
    localparam int STATUS_W = 3;
    localparam int PIXELS_W = 30;

    localparam logic [PIXELS_W-1:0] PIXELS_RESET = 30'd3145728;
    localparam logic [DIM_W-1:0]    MAX_DIM      = 16'd32767;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_JPEG  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_TRUNC     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NO_SOF    = 3'd6;

    // Result candidate handed from the parser to the size check stage.
    // When check is set, status is decided by the size check from width and height.
    typedef struct packed {
        logic                check;
        logic [STATUS_W-1:0] status;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
    } jsdp_cand_t;

endpackage

/* src/jsdp_ifs.sv */
interface jsdp_byte_if;
    import jsdp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface jsdp_result_if;
    import jsdp_pkg::*;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;

    modport source (output valid, output status, output width, output height, input ready);
    modport sink (input valid, input status, input width, input height, output ready);
endinterface

interface jsdp_cfg_if;
    import jsdp_pkg::*;
    logic                valid;
    logic                ready;
    logic [PIXELS_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* src/jpeg_sof_dimension_parser_top.sv */
// JPEG start-of-frame dimension parser.
// The bytes channel takes one file byte per request, with last set on the final
// byte of each file. A request is taken whenever valid and ready are both high.
// At most one request on the result channel is produced per file: the status and,
// for the size statuses, the width and height read from the first SOF segment.
// The cfg channel writes the pixel limit register; it is always ready and should
// only be written while no file is in flight.
// Throughput is one byte per clock cycle while the result receiver does not stall:
// the per-byte parse is a small state update between the input register and the
// candidate register. The width times height compare sits between the candidate
// register and the output register that holds the result request.
// When the result receiver stalls, the output register holds its request and the
// stages behind it keep filling; bytes.ready drops only once all stages are full.
// Reset clears the parse state and all valid flags and loads the pixel limit
// with 3145728. Bytes after a result are ignored until last, and the parser
// restarts after every last byte.
module jpeg_sof_dimension_parser_top
    import jsdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    jsdp_byte_if.sink    bytes,
    jsdp_result_if.source result,
    jsdp_cfg_if.sink     cfg
);

    logic [PIXELS_W-1:0] max_pixels_reg;
    logic                cand_valid;
    logic                cand_ready;
    jsdp_cand_t          cand;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_pixels_reg <= PIXELS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            max_pixels_reg <= cfg.data;
        end
    end

    jsdp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .cand_valid (cand_valid),
        .cand       (cand),
        .cand_ready (cand_ready)
    );

    jsdp_size_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand_valid),
        .cand       (cand),
        .cand_ready (cand_ready),
        .max_pixels (max_pixels_reg),
        .result     (result)
    );

endmodule

/* src/jsdp_parser.sv */
module jsdp_parser
    import jsdp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    jsdp_byte_if.sink    bytes,
    output logic         cand_valid,
    output jsdp_cand_t   cand,
    input  logic         cand_ready
);

    localparam logic [3:0] PH_SOI0   = 4'd0;
    localparam logic [3:0] PH_SOI1   = 4'd1;
    localparam logic [3:0] PH_SCAN   = 4'd2;
    localparam logic [3:0] PH_MARKER = 4'd3;
    localparam logic [3:0] PH_LENHI  = 4'd4;
    localparam logic [3:0] PH_LENLO  = 4'd5;
    localparam logic [3:0] PH_SKIP   = 4'd6;
    localparam logic [3:0] PH_SOF    = 4'd7;

    function automatic logic is_standalone(input logic [BYTE_W-1:0] m);
        return (m == 8'h00) || (m == 8'hD8) || (m == 8'hD9) ||
               (m >= 8'hD0 && m <= 8'hD7);
    endfunction

    function automatic logic is_sof(input logic [BYTE_W-1:0] m);
        return (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC5 && m <= 8'hC7) ||
               (m >= 8'hC9 && m <= 8'hCB) || (m >= 8'hCD && m <= 8'hCF);
    endfunction

    logic              in_valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    logic [3:0]        phase_reg, phase_next;
    logic              is_sof_reg, is_sof_next;
    logic [BYTE_W-1:0] length_high_reg, length_high_next;
    logic [DIM_W-1:0]  skip_reg, skip_next;
    logic [2:0]        index_reg, index_next;
    logic [DIM_W-1:0]  height_reg, height_next;
    logic [DIM_W-1:0]  width_reg, width_next;
    logic              given_reg, given_next;

    logic              cand_valid_reg;
    jsdp_cand_t        cand_reg;
    jsdp_cand_t        cand_next;
    logic              fire;

    logic              stage_ready;
    logic              consume;
    logic [DIM_W-1:0]  seg_len;

    assign stage_ready = !cand_valid_reg || cand_ready;
    assign consume     = in_valid_reg && stage_ready;
    assign bytes.ready = !in_valid_reg || stage_ready;
    assign seg_len     = {length_high_reg, byte_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        is_sof_next      = is_sof_reg;
        length_high_next = length_high_reg;
        skip_next        = skip_reg;
        index_next       = index_reg;
        height_next      = height_reg;
        width_next       = width_reg;
        given_next       = given_reg;
        fire             = 1'b0;
        cand_next.check  = 1'b0;
        cand_next.status = ST_OK;
        cand_next.width  = '0;
        cand_next.height = '0;

        if (!given_reg)
        begin
            unique case (phase_reg)
                PH_SOI0:
                begin
                    if (byte_reg != 8'hFF)
                    begin
                        fire             = 1'b1;
                        cand_next.status = ST_NOT_JPEG;
                    end
                    else
                    begin
                        phase_next = PH_SOI1;
                    end
                end
                PH_SOI1:
                begin
                    if (byte_reg != 8'hD8)
                    begin
                        fire             = 1'b1;
                        cand_next.status = ST_NOT_JPEG;
                    end
                    else
                    begin
                        phase_next = PH_SCAN;
                    end
                end
                PH_SCAN:
                begin
                    if (byte_reg == 8'hFF)
                    begin
                        phase_next = PH_MARKER;
                    end
                end
                PH_MARKER:
                begin
                    // A repeated 0xFF is fill and keeps us waiting for the marker code.
                    if (byte_reg != 8'hFF)
                    begin
                        if (is_standalone(byte_reg))
                        begin
                            phase_next = PH_SCAN;
                        end
                        else
                        begin
                            is_sof_next = is_sof(byte_reg);
                            phase_next  = PH_LENHI;
                        end
                    end
                end
                PH_LENHI:
                begin
                    length_high_next = byte_reg;
                    phase_next       = PH_LENLO;
                end
                PH_LENLO:
                begin
                    if (seg_len < 16'd2 || (is_sof_reg && seg_len < 16'd7))
                    begin
                        fire             = 1'b1;
                        cand_next.status = ST_BAD_LEN;
                    end
                    else if (is_sof_reg)
                    begin
                        index_next = '0;
                        phase_next = PH_SOF;
                    end
                    else
                    begin
                        skip_next  = seg_len - 16'd2;
                        phase_next = (seg_len == 16'd2) ? PH_SCAN : PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_next = skip_reg - 16'd1;
                    if (skip_reg == 16'd1)
                    begin
                        phase_next = PH_SCAN;
                    end
                end
                PH_SOF:
                begin
                    index_next = index_reg + 3'd1;
                    unique case (index_reg)
                        3'd1:    height_next = {byte_reg, 8'h00};
                        3'd2:    height_next = {height_reg[15:8], byte_reg};
                        3'd3:    width_next  = {byte_reg, 8'h00};
                        3'd4:
                        begin
                            width_next       = {width_reg[15:8], byte_reg};
                            index_next       = index_reg;
                            fire             = 1'b1;
                            cand_next.check  = 1'b1;
                            cand_next.width  = {width_reg[15:8], byte_reg};
                            cand_next.height = height_reg;
                        end
                        default: ;
                    endcase
                end
                default: phase_next = PH_SCAN;
            endcase
        end

        if (fire)
        begin
            given_next = 1'b1;
        end

        // The last byte closes the file: if nothing was reported yet, report where parsing stopped, then restart.
        if (last_reg)
        begin
            if (!given_reg && !fire)
            begin
                fire = 1'b1;
                if (phase_next == PH_SOI0 || phase_next == PH_SOI1)
                begin
                    cand_next.status = ST_NOT_JPEG;
                end
                else if (phase_next == PH_SCAN)
                begin
                    cand_next.status = ST_NO_SOF;
                end
                else
                begin
                    cand_next.status = ST_TRUNC;
                end
            end
            phase_next       = PH_SOI0;
            is_sof_next      = 1'b0;
            length_high_next = '0;
            skip_next        = '0;
            index_next       = '0;
            height_next      = '0;
            width_next       = '0;
            given_next       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg    <= 1'b0;
            cand_valid_reg  <= 1'b0;
            phase_reg       <= PH_SOI0;
            is_sof_reg      <= 1'b0;
            length_high_reg <= '0;
            skip_reg        <= '0;
            index_reg       <= '0;
            height_reg      <= '0;
            width_reg       <= '0;
            given_reg       <= 1'b0;
        end
        else
        begin
            if (bytes.ready)
            begin
                in_valid_reg <= bytes.valid;
            end
            if (stage_ready)
            begin
                cand_valid_reg <= consume && fire;
            end
            if (consume)
            begin
                phase_reg       <= phase_next;
                is_sof_reg      <= is_sof_next;
                length_high_reg <= length_high_next;
                skip_reg        <= skip_next;
                index_reg       <= index_next;
                height_reg      <= height_next;
                width_reg       <= width_next;
                given_reg       <= given_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (bytes.valid && bytes.ready)
        begin
            byte_reg <= bytes.data_byte;
            last_reg <= bytes.last;
        end
        if (stage_ready)
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand_valid = cand_valid_reg;
    assign cand       = cand_reg;

endmodule

/* src/jsdp_size_check.sv */
module jsdp_size_check
    import jsdp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cand_valid,
    input  jsdp_cand_t          cand,
    output logic                cand_ready,
    input  logic [PIXELS_W-1:0] max_pixels,
    jsdp_result_if.source       result
);

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [PIXELS_W-1:0] product;

    assign cand_ready = !out_valid_reg || result.ready;

    // Only consulted when both sides fit in 15 bits, so the product fits in 30.
    assign product = PIXELS_W'(cand.width[14:0]) * PIXELS_W'(cand.height[14:0]);

    always_comb
    begin
        status_next = cand.status;
        if (cand.check)
        begin
            if (cand.width == '0 || cand.height == '0)
            begin
                status_next = ST_ZERO;
            end
            else if (cand.width > MAX_DIM || cand.height > MAX_DIM || product > max_pixels)
            begin
                status_next = ST_TOO_LARGE;
            end
            else
            begin
                status_next = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cand_ready)
        begin
            out_valid_reg <= cand_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cand_ready && cand_valid)
        begin
            status_reg <= status_next;
            width_reg  <= cand.width;
            height_reg <= cand.height;
        end
    end

    assign result.valid  = out_valid_reg;
    assign result.status = status_reg;
    assign result.width  = width_reg;
    assign result.height = height_reg;

endmodule

/* src/jsdp_checker.sv */
module jsdp_checker
    import jsdp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                res_valid,
    input logic                res_ready,
    input logic [STATUS_W-1:0] res_status,
    input logic [DIM_W-1:0]    res_width,
    input logic [DIM_W-1:0]    res_height
);

    // Statuses that come before any SOF dimensions carry zero dimensions.
    a_no_dims: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_NOT_JPEG || res_status == ST_TRUNC ||
                      res_status == ST_BAD_LEN || res_status == ST_NO_SOF)
        |-> res_width == '0 && res_height == '0)
        else $error("dimensions reported with a non-size status");

    a_ok_dims: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_OK
        |-> res_width != '0 && res_height != '0 &&
            res_width <= MAX_DIM && res_height <= MAX_DIM)
        else $error("ok status with out-of-range dimensions");

    a_zero_dims: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_status == ST_ZERO |-> res_width == '0 || res_height == '0)
        else $error("zero_size status with nonzero dimensions");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_status != 3'd7)
        else $error("undefined status code");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready
        |=> res_valid && $stable(res_status) && $stable(res_width) && $stable(res_height))
        else $error("stalled result request changed");

endmodule

bind jpeg_sof_dimension_parser_top jsdp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (result.valid),
    .res_ready  (result.ready),
    .res_status (result.status),
    .res_width  (result.width),
    .res_height (result.height)
);
